// ----- rtl/core/pulse_envelope_generator_assert.svh -----
// Assertion helpers shared by the envelope generator RTL.
`ifndef PULSE_ENVELOPE_GENERATOR_ASSERT_SVH
`define PULSE_ENVELOPE_GENERATOR_ASSERT_SVH

// Property that must hold at every edge outside reset.
`define PEG_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("peg assertion failed");

// Same-cycle implication, checked outside reset.
`define PEG_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("peg implication failed");

`endif

// ----- rtl/core/peg_pkg.sv -----
package peg_pkg;

   localparam int DATA_WIDTH      = 16;
   localparam int CSR_INDEX_WIDTH = 3;

   // register indexes
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_FINAL_SIZE      = 3'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_EXPAND_SPEED    = 3'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_EXPAND_ACCEL    = 3'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_EXPAND_LIMIT    = 3'd3;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_CONTRACT_SPEED  = 3'd4;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_CONTRACT_ACCEL  = 3'd5;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_CONTRACT_LIMIT  = 3'd6;

   // command codes on the input word
   localparam logic [2:0] CMD_TICK      = 3'd0;
   localparam logic [2:0] CMD_START     = 3'd1;
   localparam logic [2:0] CMD_PAUSE     = 3'd2;
   localparam logic [2:0] CMD_STOP_END  = 3'd3;
   localparam logic [2:0] CMD_STOP_NOW  = 3'd4;

   // classified operations passed from front to back
   localparam logic [2:0] OP_NONE       = 3'd0;
   localparam logic [2:0] OP_TICK       = 3'd1;
   localparam logic [2:0] OP_START      = 3'd2;
   localparam logic [2:0] OP_PAUSE      = 3'd3;
   localparam logic [2:0] OP_STOP_END   = 3'd4;
   localparam logic [2:0] OP_STOP_NOW   = 3'd5;

   // phase codes
   localparam logic [1:0] PH_STOPPED    = 2'd0;
   localparam logic [1:0] PH_EXPAND     = 2'd1;
   localparam logic [1:0] PH_CONTRACT   = 2'd2;
   localparam logic [1:0] PH_PAUSED     = 2'd3;

   localparam logic [DATA_WIDTH-1:0] ONE_Q12 = 16'd4096;

   typedef struct packed {
      logic [2:0]             command;
      logic [DATA_WIDTH-1:0]  delta_time;
   } peg_req_type;

   typedef struct packed {
      logic [DATA_WIDTH-1:0]  relative_size;
      logic [1:0]             phase;
      logic                   turned;
   } peg_rsp_type;

   typedef struct packed {
      logic [2:0]             op;
      logic [DATA_WIDTH-1:0]  delta_time;
   } peg_op_type;

   typedef struct packed {
      logic [DATA_WIDTH-1:0]  final_relative_size;
      logic [DATA_WIDTH-1:0]  expand_start_speed;
      logic [DATA_WIDTH-1:0]  expand_accel;
      logic [DATA_WIDTH-1:0]  expand_speed_limit;
      logic [DATA_WIDTH-1:0]  contract_start_speed;
      logic [DATA_WIDTH-1:0]  contract_accel;
      logic [DATA_WIDTH-1:0]  contract_speed_limit;
   } peg_cfg_type;

endpackage

// ----- rtl/core/pulse_envelope_generator.sv -----
// Pulse envelope generator: ramps a Q4.12 relative size between 1.0 and the
// programmed far bound, one command word at a time (tick, start, pause, stop
// at cycle end, stop now), and returns one result word per command with the
// size, the phase and whether a bound was reached. Throughput is one word per
// clock while the result queue has room; each command passes the command
// queue, then the state update in the back stage, whose speed-times-time
// products are the critical path. Command and result queues hold QUEUE_DEPTH
// and RESULT_DEPTH words (powers of two, at least 2). The user must write
// registers only while the block is idle; the block does not enforce this.
module pulse_envelope_generator import peg_pkg::*; #(
   parameter int QUEUE_DEPTH  = 2,
   parameter int RESULT_DEPTH = 2
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   output logic                       full,
   input  peg_req_type                req_word,
   output logic                       empty,
   input  logic                       pop,
   output peg_rsp_type                rsp_word,
   input  logic                       csr_write,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [DATA_WIDTH-1:0]      csr_wdata
);

   peg_cfg_type cfg;
   peg_op_type  op_word;
   logic        op_empty, op_pop;

   peg_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   peg_front #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .full     (full),
      .req_word (req_word),
      .op_pop   (op_pop),
      .op_empty (op_empty),
      .op_word  (op_word)
   );

   peg_back #(
      .RESULT_DEPTH (RESULT_DEPTH)
   ) u_back (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg),
      .op_empty (op_empty),
      .op_pop   (op_pop),
      .op_word  (op_word),
      .empty    (empty),
      .pop      (pop),
      .rsp_word (rsp_word)
   );

endmodule

// ----- rtl/core/peg_csr.sv -----
module peg_csr import peg_pkg::*; (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_write,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [DATA_WIDTH-1:0]      csr_wdata,
   output peg_cfg_type                cfg
);

   peg_cfg_type cfg_ff, cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         unique case (csr_index)
            CSR_FINAL_SIZE:     cfg_in.final_relative_size  = csr_wdata;
            CSR_EXPAND_SPEED:   cfg_in.expand_start_speed   = csr_wdata;
            CSR_EXPAND_ACCEL:   cfg_in.expand_accel         = csr_wdata;
            CSR_EXPAND_LIMIT:   cfg_in.expand_speed_limit   = csr_wdata;
            CSR_CONTRACT_SPEED: cfg_in.contract_start_speed = csr_wdata;
            CSR_CONTRACT_ACCEL: cfg_in.contract_accel       = csr_wdata;
            CSR_CONTRACT_LIMIT: cfg_in.contract_speed_limit = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.final_relative_size  <= 16'd8192;
         cfg_ff.expand_start_speed   <= ONE_Q12;
         cfg_ff.expand_accel         <= '0;
         cfg_ff.expand_speed_limit   <= ONE_Q12;
         cfg_ff.contract_start_speed <= ONE_Q12;
         cfg_ff.contract_accel       <= '0;
         cfg_ff.contract_speed_limit <= ONE_Q12;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ----- rtl/core/peg_fifo.sv -----
`include "pulse_envelope_generator_assert.svh"

module peg_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             empty
);

   // DEPTH is a power of two, at least 2
   localparam int AW = $clog2(DEPTH);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [AW:0]      wr_ptr_ff, wr_ptr_in;
   logic [AW:0]      rd_ptr_ff, rd_ptr_in;
   logic [AW:0]      count;
   logic             do_push, do_pop;

   assign count   = wr_ptr_ff - rd_ptr_ff;
   assign full    = (count == (AW+1)'(DEPTH));
   assign empty   = (count == '0);
   assign do_push = push & ~full;
   assign do_pop  = pop & ~empty;

   assign wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
   assign rd_ptr_in = do_pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff[AW-1:0]] <= push_data;
      end
   end

   assign pop_data = mem_ff[rd_ptr_ff[AW-1:0]];

   `PEG_ASSERT(fifo_count_bounded, clock, reset, count <= (AW+1)'(DEPTH))
   `PEG_ASSERT(fifo_count_tracks, clock, reset,
      $past(reset) ||
      count == $past(count) + (AW+1)'($past(do_push)) - (AW+1)'($past(do_pop)))
   `PEG_ASSERT_IMPLY(fifo_full_not_empty, clock, reset, full, !empty)

endmodule

// ----- rtl/core/peg_front.sv -----
module peg_front import peg_pkg::*; #(
   parameter int QUEUE_DEPTH = 2
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   output logic        full,
   input  peg_req_type req_word,
   input  logic        op_pop,
   output logic        op_empty,
   output peg_op_type  op_word
);

   peg_op_type cls_word;
   logic [$bits(peg_op_type)-1:0] op_bits;

   always_comb begin
      cls_word.delta_time = req_word.delta_time;
      unique case (req_word.command)
         CMD_TICK:     cls_word.op = OP_TICK;
         CMD_START:    cls_word.op = OP_START;
         CMD_PAUSE:    cls_word.op = OP_PAUSE;
         CMD_STOP_END: cls_word.op = OP_STOP_END;
         CMD_STOP_NOW: cls_word.op = OP_STOP_NOW;
         default:      cls_word.op = OP_NONE;
      endcase
   end

   peg_fifo #(
      .WIDTH ($bits(peg_op_type)),
      .DEPTH (QUEUE_DEPTH)
   ) u_op_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (cls_word),
      .full      (full),
      .pop       (op_pop),
      .pop_data  (op_bits),
      .empty     (op_empty)
   );

   assign op_word = peg_op_type'(op_bits);

endmodule

// ----- rtl/core/peg_back.sv -----
`include "pulse_envelope_generator_assert.svh"

module peg_back import peg_pkg::*; #(
   parameter int RESULT_DEPTH = 2
) (
   input  logic        clock,
   input  logic        reset,
   input  peg_cfg_type cfg,
   input  logic        op_empty,
   output logic        op_pop,
   input  peg_op_type  op_word,
   output logic        empty,
   input  logic        pop,
   output peg_rsp_type rsp_word
);

   logic [1:0]            phase_ff, phase_in;
   logic [1:0]            resume_ff, resume_in;
   logic                  pending_ff, pending_in;
   logic [DATA_WIDTH-1:0] size_ff, size_in;
   logic [DATA_WIDTH-1:0] speed_ff, speed_in;

   logic                  res_full, res_push;
   peg_rsp_type           res_word;
   logic [$bits(peg_rsp_type)-1:0] rsp_bits;

   logic                  running, expanding, first_contract, cycle_end, reached, turned;
   logic [DATA_WIDTH-1:0] lo_bound, hi_bound, target, gap, moved, new_size, step;
   logic [2*DATA_WIDTH-1:0] step_prod;
   logic [DATA_WIDTH-1:0] accel, limit, speed_next;
   logic signed [2*DATA_WIDTH:0]   acc_prod;
   logic signed [DATA_WIDTH:0]     change;
   logic signed [DATA_WIDTH+1:0]   speed_sum, speed_clamp, limit_ext;
   logic                  accel_pos, accel_neg;

   assign op_pop   = ~op_empty & ~res_full;
   assign res_push = op_pop;

   assign running        = (phase_ff == PH_EXPAND) || (phase_ff == PH_CONTRACT);
   assign expanding      = (phase_ff == PH_EXPAND);
   assign first_contract = (cfg.final_relative_size < ONE_Q12);
   assign lo_bound       = first_contract ? cfg.final_relative_size : ONE_Q12;
   assign hi_bound       = first_contract ? ONE_Q12 : cfg.final_relative_size;
   assign target         = expanding ? hi_bound : lo_bound;
   assign cycle_end      = expanding ? first_contract : ~first_contract;

   // position update
   always_comb begin
      step_prod = {{DATA_WIDTH{1'b0}}, speed_ff} * {{DATA_WIDTH{1'b0}}, op_word.delta_time};
      step      = step_prod[2*DATA_WIDTH-1:DATA_WIDTH];
      if (size_ff <= target) begin
         gap   = target - size_ff;
         moved = size_ff + step;
      end else begin
         gap   = size_ff - target;
         moved = size_ff - step;
      end
      reached  = (gap <= step);
      new_size = reached ? target : moved;
   end

   // speed update: floor(accel * dt / 2^16), clamp at limit, saturate
   always_comb begin
      accel       = expanding ? cfg.expand_accel : cfg.contract_accel;
      limit       = expanding ? cfg.expand_speed_limit : cfg.contract_speed_limit;
      accel_neg   = accel[DATA_WIDTH-1];
      accel_pos   = ~accel_neg && (accel != '0);
      acc_prod    = $signed({{(DATA_WIDTH+1){accel[DATA_WIDTH-1]}}, accel})
                  * $signed({{(DATA_WIDTH+1){1'b0}}, op_word.delta_time});
      change      = acc_prod[2*DATA_WIDTH:DATA_WIDTH];
      speed_sum   = $signed({2'b00, speed_ff}) + $signed({change[DATA_WIDTH], change});
      limit_ext   = $signed({2'b00, limit});
      speed_clamp = speed_sum;
      if (accel_pos && speed_sum > limit_ext) begin
         speed_clamp = limit_ext;
      end
      if (accel_neg && speed_sum < limit_ext) begin
         speed_clamp = limit_ext;
      end
      if (!accel_pos && !accel_neg) begin
         speed_next = speed_ff;
      end else if (speed_clamp[DATA_WIDTH+1]) begin
         speed_next = '0;
      end else if (speed_clamp[DATA_WIDTH]) begin
         speed_next = '1;
      end else begin
         speed_next = speed_clamp[DATA_WIDTH-1:0];
      end
   end

   always_comb begin
      phase_in   = phase_ff;
      resume_in  = resume_ff;
      pending_in = pending_ff;
      size_in    = size_ff;
      speed_in   = speed_ff;
      turned     = 1'b0;
      unique case (op_word.op)
         OP_TICK: begin
            if (running) begin
               size_in  = new_size;
               speed_in = speed_next;
               turned   = reached;
               if (reached) begin
                  if (pending_ff && cycle_end) begin
                     phase_in   = PH_STOPPED;
                     size_in    = ONE_Q12;
                     pending_in = 1'b0;
                  end else if (expanding) begin
                     phase_in = PH_CONTRACT;
                     speed_in = cfg.contract_start_speed;
                  end else begin
                     phase_in = PH_EXPAND;
                     speed_in = cfg.expand_start_speed;
                  end
               end
            end
         end
         OP_START: begin
            if (phase_ff == PH_STOPPED) begin
               phase_in = first_contract ? PH_CONTRACT : PH_EXPAND;
               speed_in = first_contract ? cfg.contract_start_speed
                                         : cfg.expand_start_speed;
               size_in  = ONE_Q12;
            end else if (phase_ff == PH_PAUSED) begin
               phase_in = resume_ff;
            end
         end
         OP_PAUSE: begin
            if (running) begin
               resume_in = phase_ff;
               phase_in  = PH_PAUSED;
            end
         end
         OP_STOP_END: begin
            pending_in = 1'b1;
         end
         OP_STOP_NOW: begin
            phase_in   = PH_STOPPED;
            size_in    = ONE_Q12;
            pending_in = 1'b0;
         end
         default: ;
      endcase
   end

   always_comb begin
      res_word.relative_size = (phase_in == PH_STOPPED) ? ONE_Q12 : size_in;
      res_word.phase         = phase_in;
      res_word.turned        = turned;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_STOPPED;
         resume_ff  <= PH_STOPPED;
         pending_ff <= 1'b0;
         size_ff    <= ONE_Q12;
         speed_ff   <= '0;
      end else if (op_pop) begin
         phase_ff   <= phase_in;
         resume_ff  <= resume_in;
         pending_ff <= pending_in;
         size_ff    <= size_in;
         speed_ff   <= speed_in;
      end
   end

   peg_fifo #(
      .WIDTH ($bits(peg_rsp_type)),
      .DEPTH (RESULT_DEPTH)
   ) u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (res_push),
      .push_data (res_word),
      .full      (res_full),
      .pop       (pop),
      .pop_data  (rsp_bits),
      .empty     (empty)
   );

   assign rsp_word = peg_rsp_type'(rsp_bits);

   `PEG_ASSERT(stopped_size_is_one, clock, reset,
      phase_ff != PH_STOPPED || size_ff == ONE_Q12)
   `PEG_ASSERT(paused_can_resume, clock, reset,
      phase_ff != PH_PAUSED || resume_ff == PH_EXPAND || resume_ff == PH_CONTRACT)
   `PEG_ASSERT_IMPLY(turn_only_on_tick, clock, reset,
      res_push && res_word.turned, op_word.op == OP_TICK && running)

endmodule

// ----- tb/sv/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;
   import peg_pkg::*;

   // command codes the block must ignore
   localparam logic [2:0] CMD_RESERVED_FIRST = 3'd5;
   localparam logic [2:0] CMD_RESERVED_LAST  = 3'd7;

   localparam int PHASE_COUNT     = 10;
   localparam int WORDS_PER_PHASE = 125;
   localparam int HOLD_CYCLES     = 250;
   localparam int STALL_LIMIT     = 3000;

   typedef struct {
      peg_req_type word;
      bit          typed;
      peg_rsp_type rsp;
   } stim_row_type;

   logic                       clock     = 1'b0;
   logic                       reset     = 1'b1;
   logic                       push      = 1'b0;
   logic                       full;
   peg_req_type                req_word  = '0;
   logic                       empty;
   logic                       pop       = 1'b0;
   peg_rsp_type                rsp_word;
   logic                       csr_write = 1'b0;
   logic [CSR_INDEX_WIDTH-1:0] csr_index = '0;
   logic [DATA_WIDTH-1:0]      csr_wdata = '0;

   // envelope state and register copy tracked by the predictor
   peg_cfg_type           cfg = '{16'd8192, 16'd4096, 16'd0, 16'd4096, 16'd4096, 16'd0, 16'd4096};
   logic [1:0]            env_phase       = PH_STOPPED;
   logic [1:0]            env_phase_saved = PH_STOPPED;
   logic                  env_stop_armed  = 1'b0;
   logic [DATA_WIDTH-1:0] env_size        = ONE_Q12;
   logic [DATA_WIDTH-1:0] env_speed       = '0;

   peg_rsp_type  pending_results[$];
   stim_row_type directed_rows[$];
   int           error_count = 0;

   // typed-in expectation for the word being offered, if any
   bit          row_typed = 1'b0;
   peg_rsp_type row_rsp   = '0;

   int idle_pct  = 0;
   int stall_pct = 0;
   bit hold_go   = 1'b0;
   bit hold_done = 1'b0;
   int hold_left = 0;
   int quiet_cycles = 0;

   pulse_envelope_generator dut (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .full      (full),
      .req_word  (req_word),
      .empty     (empty),
      .pop       (pop),
      .rsp_word  (rsp_word),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #6 clock = ~clock;

   function automatic logic [DATA_WIDTH-1:0] ramp_speed(logic [DATA_WIDTH-1:0] speed,
                                                        logic [DATA_WIDTH-1:0] accel,
                                                        logic [DATA_WIDTH-1:0] limit,
                                                        logic [DATA_WIDTH-1:0] dt);
      longint change;
      longint s;
      if (accel == '0) return speed;
      // arithmetic shift floors toward minus infinity
      change = (longint'(signed'(accel)) * longint'(dt)) >>> 16;
      s = longint'(speed) + change;
      if (!accel[DATA_WIDTH-1]) begin
         if (s > longint'(limit)) s = longint'(limit);
      end else if (s < longint'(limit)) begin
         s = longint'(limit);
      end
      if (s < 0) s = 0;
      if (s > 65535) s = 65535;
      return s[DATA_WIDTH-1:0];
   endfunction

   function automatic void envelope_halt();
      env_phase      = PH_STOPPED;
      env_size       = ONE_Q12;
      env_stop_armed = 1'b0;
   endfunction

   function automatic logic envelope_tick(logic [DATA_WIDTH-1:0] dt);
      logic        expanding;
      logic        contract_first;
      logic        reached;
      logic [31:0] prod;
      int          lo;
      int          hi;
      int          target;
      int          step;
      int          level;
      expanding      = (env_phase == PH_EXPAND);
      contract_first = (cfg.final_relative_size < ONE_Q12);
      if (contract_first) begin
         lo = int'(cfg.final_relative_size);
         hi = int'(ONE_Q12);
      end else begin
         lo = int'(ONE_Q12);
         hi = int'(cfg.final_relative_size);
      end
      target = expanding ? hi : lo;
      prod   = 32'(env_speed) * 32'(dt);
      step   = int'(prod >> 16);
      level  = int'(env_size);
      if (level <= target) begin
         reached = (target - level <= step);
         level   = reached ? target : level + step;
      end else begin
         reached = (level - target <= step);
         level   = reached ? target : level - step;
      end
      env_size = level[DATA_WIDTH-1:0];
      if (expanding)
         env_speed = ramp_speed(env_speed, cfg.expand_accel, cfg.expand_speed_limit, dt);
      else
         env_speed = ramp_speed(env_speed, cfg.contract_accel, cfg.contract_speed_limit, dt);
      if (reached) begin
         // a full cycle closes on the return to 1.0
         if (env_stop_armed && (expanding == contract_first)) begin
            envelope_halt();
         end else if (expanding) begin
            env_speed = cfg.contract_start_speed;
            env_phase = PH_CONTRACT;
         end else begin
            env_speed = cfg.expand_start_speed;
            env_phase = PH_EXPAND;
         end
      end
      return reached;
   endfunction

   function automatic peg_rsp_type envelope_step(peg_req_type w);
      peg_rsp_type r;
      logic        hit;
      hit = 1'b0;
      case (w.command)
         CMD_TICK: begin
            if (env_phase == PH_EXPAND || env_phase == PH_CONTRACT)
               hit = envelope_tick(w.delta_time);
         end
         CMD_START: begin
            if (env_phase == PH_STOPPED) begin
               if (cfg.final_relative_size < ONE_Q12) begin
                  env_phase = PH_CONTRACT;
                  env_speed = cfg.contract_start_speed;
               end else begin
                  env_phase = PH_EXPAND;
                  env_speed = cfg.expand_start_speed;
               end
               env_size = ONE_Q12;
            end else if (env_phase == PH_PAUSED) begin
               env_phase = env_phase_saved;
            end
         end
         CMD_PAUSE: begin
            if (env_phase == PH_EXPAND || env_phase == PH_CONTRACT) begin
               env_phase_saved = env_phase;
               env_phase       = PH_PAUSED;
            end
         end
         CMD_STOP_END: env_stop_armed = 1'b1;
         CMD_STOP_NOW: envelope_halt();
         default: ;
      endcase
      r.relative_size = (env_phase == PH_STOPPED) ? ONE_Q12 : env_size;
      r.phase         = env_phase;
      r.turned        = hit;
      return r;
   endfunction

   // sample everything at the rising edge
   always @(posedge clock) begin
      peg_rsp_type want;
      peg_rsp_type got;
      if (!reset) begin
         if (csr_write) begin
            case (csr_index)
               CSR_FINAL_SIZE:     cfg.final_relative_size  = csr_wdata;
               CSR_EXPAND_SPEED:   cfg.expand_start_speed   = csr_wdata;
               CSR_EXPAND_ACCEL:   cfg.expand_accel         = csr_wdata;
               CSR_EXPAND_LIMIT:   cfg.expand_speed_limit   = csr_wdata;
               CSR_CONTRACT_SPEED: cfg.contract_start_speed = csr_wdata;
               CSR_CONTRACT_ACCEL: cfg.contract_accel       = csr_wdata;
               CSR_CONTRACT_LIMIT: cfg.contract_speed_limit = csr_wdata;
               default: ;
            endcase
         end
         if (push && !full) begin
            want = envelope_step(req_word);
            pending_results.insert(pending_results.size(), row_typed ? row_rsp : want);
         end
         if (pop && !empty) begin
            got = rsp_word;
            if (pending_results.size() == 0) begin
               $error("result word with nothing expected: size %0d phase %0d turned %0d",
                      got.relative_size, got.phase, got.turned);
               error_count++;
            end else begin
               want = pending_results.pop_front();
               if (got.relative_size !== want.relative_size) begin
                  $error("relative_size: expected %0d, got %0d",
                         want.relative_size, got.relative_size);
                  error_count++;
               end
               if (got.phase !== want.phase) begin
                  $error("phase: expected %0d, got %0d", want.phase, got.phase);
                  error_count++;
               end
               if (got.turned !== want.turned) begin
                  $error("turned: expected %0d, got %0d", want.turned, got.turned);
                  error_count++;
               end
            end
         end
      end
   end

   // result side; a one-time long hold-off lets the block fill up
   always @(negedge clock) begin
      if (hold_go && !hold_done) begin
         hold_done = 1'b1;
         hold_left = HOLD_CYCLES;
      end
      if (reset) begin
         pop <= 1'b0;
      end else if (hold_left > 0) begin
         pop <= 1'b0;
         hold_left--;
      end else begin
         pop <= ($urandom_range(99) >= stall_pct);
      end
   end

   always @(posedge clock) begin
      if ((push && !full) || (pop && !empty) || csr_write) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("pulse_envelope_generator regression: fail");
            $finish;
         end
      end
   end

   function automatic void add_row(logic [2:0] cmd, logic [DATA_WIDTH-1:0] dt, bit typed,
                                   logic [DATA_WIDTH-1:0] level, logic [1:0] ph,
                                   logic turned);
      stim_row_type row;
      row.word.command    = cmd;
      row.word.delta_time = dt;
      row.typed           = typed;
      row.rsp             = '{relative_size: level, phase: ph, turned: turned};
      directed_rows.insert(directed_rows.size(), row);
   endfunction

   task automatic send_word(peg_req_type w, bit typed, peg_rsp_type rsp);
      @(negedge clock);
      while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
         push <= 1'b0;
         @(negedge clock);
      end
      row_typed = typed;
      row_rsp   = rsp;
      push     <= 1'b1;
      req_word <= w;
      @(posedge clock);
      while (full) @(posedge clock);
   endtask

   task automatic write_reg(logic [CSR_INDEX_WIDTH-1:0] idx, logic [DATA_WIDTH-1:0] value);
      @(negedge clock);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(negedge clock);
      csr_write <= 1'b0;
   endtask

   task automatic drain_results();
      @(negedge clock);
      push <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (6) @(posedge clock);
   endtask

   function automatic peg_cfg_type phase_setting(int k);
      peg_cfg_type s;
      s.final_relative_size  = ($urandom_range(3) == 0) ? 16'($urandom_range(4095))
                                                         : 16'($urandom_range(65535, 4097));
      s.expand_start_speed   = 16'($urandom_range(65535));
      s.expand_accel         = 16'($urandom);
      s.expand_speed_limit   = 16'($urandom_range(65535));
      s.contract_start_speed = 16'($urandom_range(65535));
      s.contract_accel       = 16'($urandom);
      s.contract_speed_limit = 16'($urandom_range(65535));
      case (k)
         0: s.final_relative_size = ONE_Q12;
         1: s = '{16'd0, 16'hFFFF, 16'h7FFF, 16'hFFFF, 16'hFFFF, 16'h8000, 16'd0};
         2: s = '{16'hFFFF, 16'd0, 16'h7FFF, 16'hFFFF, 16'd0, 16'h7FFF, 16'hFFFF};
         // negative accel with a limit above the speed pins it at the limit
         3: s = '{ONE_Q12 - 16'd1, 16'd300, 16'h8000, 16'hFFFF, 16'd900, 16'h7FFF, 16'd0};
         4: begin
            s.final_relative_size = ONE_Q12 + 16'd1;
            s.expand_accel        = '0;
            s.contract_accel      = '0;
         end
         5: s = '{16'd8192, 16'd4096, 16'd0, 16'd4096, 16'd4096, 16'd0, 16'd4096};
         default: ;
      endcase
      return s;
   endfunction

   function automatic peg_req_type random_word();
      peg_req_type w;
      int          pick;
      pick = $urandom_range(99);
      if (pick < 68)      w.command = CMD_TICK;
      else if (pick < 78) w.command = CMD_START;
      else if (pick < 85) w.command = CMD_PAUSE;
      else if (pick < 90) w.command = CMD_STOP_END;
      else if (pick < 95) w.command = CMD_STOP_NOW;
      else w.command = 3'($urandom_range(CMD_RESERVED_LAST, CMD_RESERVED_FIRST));
      case ($urandom_range(9))
         0:       w.delta_time = '0;
         1:       w.delta_time = '1;
         2, 3, 4: w.delta_time = 16'($urandom_range(4095));
         default: w.delta_time = 16'($urandom);
      endcase
      return w;
   endfunction

   initial begin
      peg_cfg_type setting;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset settings: far bound 2.0, all speeds 1.0/s, no acceleration
      add_row(CMD_TICK,           16'hFFFF, 1'b1, ONE_Q12,  PH_STOPPED,  1'b0);
      add_row(CMD_PAUSE,          16'h0000, 1'b1, ONE_Q12,  PH_STOPPED,  1'b0);
      add_row(CMD_RESERVED_FIRST, 16'h5A5A, 1'b1, ONE_Q12,  PH_STOPPED,  1'b0);
      add_row(CMD_RESERVED_LAST,  16'hA5A5, 1'b1, ONE_Q12,  PH_STOPPED,  1'b0);
      add_row(CMD_START,          16'h0000, 1'b1, ONE_Q12,  PH_EXPAND,   1'b0);
      add_row(CMD_START,          16'hFFFF, 1'b1, ONE_Q12,  PH_EXPAND,   1'b0);
      add_row(CMD_TICK,           16'h0000, 1'b1, ONE_Q12,  PH_EXPAND,   1'b0);
      add_row(CMD_TICK,           16'h8000, 1'b1, 16'd6144, PH_EXPAND,   1'b0);
      add_row(CMD_PAUSE,          16'h0000, 1'b1, 16'd6144, PH_PAUSED,   1'b0);
      add_row(CMD_PAUSE,          16'h0000, 1'b1, 16'd6144, PH_PAUSED,   1'b0);
      add_row(CMD_TICK,           16'hFFFF, 1'b1, 16'd6144, PH_PAUSED,   1'b0);
      add_row(CMD_START,          16'h0000, 1'b1, 16'd6144, PH_EXPAND,   1'b0);
      add_row(CMD_TICK,           16'hFFFF, 1'b1, 16'd8192, PH_CONTRACT, 1'b1);
      add_row(CMD_STOP_END,       16'h0000, 1'b1, 16'd8192, PH_CONTRACT, 1'b0);
      add_row(CMD_TICK,           16'hFFFF, 1'b1, 16'd4097, PH_CONTRACT, 1'b0);
      add_row(CMD_TICK,           16'd16,   1'b1, ONE_Q12,  PH_STOPPED,  1'b1);
      add_row(CMD_STOP_NOW,       16'h0000, 1'b1, ONE_Q12,  PH_STOPPED,  1'b0);
      // armed stop must not fire at the far bound
      add_row(CMD_STOP_END,       16'h0000, 1'b0, '0, PH_STOPPED, 1'b0);
      add_row(CMD_START,          16'h0000, 1'b0, '0, PH_STOPPED, 1'b0);
      add_row(CMD_TICK,           16'hFFFF, 1'b0, '0, PH_STOPPED, 1'b0);
      add_row(CMD_TICK,           16'd16,   1'b0, '0, PH_STOPPED, 1'b0);
      add_row(CMD_STOP_NOW,       16'h0000, 1'b0, '0, PH_STOPPED, 1'b0);
      add_row(CMD_START,          16'h0000, 1'b0, '0, PH_STOPPED, 1'b0);
      add_row(CMD_PAUSE,          16'h0000, 1'b0, '0, PH_STOPPED, 1'b0);
      add_row(CMD_STOP_NOW,       16'h0000, 1'b0, '0, PH_STOPPED, 1'b0);
      foreach (directed_rows[i])
         send_word(directed_rows[i].word, directed_rows[i].typed, directed_rows[i].rsp);
      row_typed = 1'b0;

      for (int k = 0; k < PHASE_COUNT; k++) begin
         drain_results();
         setting = phase_setting(k);
         write_reg(CSR_FINAL_SIZE,     setting.final_relative_size);
         write_reg(CSR_EXPAND_SPEED,   setting.expand_start_speed);
         write_reg(CSR_EXPAND_ACCEL,   setting.expand_accel);
         write_reg(CSR_EXPAND_LIMIT,   setting.expand_speed_limit);
         write_reg(CSR_CONTRACT_SPEED, setting.contract_start_speed);
         write_reg(CSR_CONTRACT_ACCEL, setting.contract_accel);
         write_reg(CSR_CONTRACT_LIMIT, setting.contract_speed_limit);
         case (k % 4)
            0: begin idle_pct = 0;  stall_pct = 0;  end
            1: begin idle_pct = 47; stall_pct = 0;  end
            2: begin idle_pct = 0;  stall_pct = 47; end
            default: begin idle_pct = 38; stall_pct = 38; end
         endcase
         if (k == 4) hold_go = 1'b1;
         for (int n = 0; n < WORDS_PER_PHASE; n++)
            send_word(random_word(), 1'b0, '0);
      end

      drain_results();
      if (error_count == 0 && pending_results.size() == 0)
         $display("pulse_envelope_generator regression: pass");
      else
         $display("pulse_envelope_generator regression: fail");
      $finish;
   end

endmodule
